// ----- hw/rtl/i2p_pkg.sv -----
// Shared types, constants and character classification for the infix-to-postfix converter.
package i2p_pkg;

   // Transaction kinds on the request channel
   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   // Error codes carried on the last response of a run
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_FULL      = 2'd1;
   localparam logic [1:0] ERR_UNMATCHED = 2'd2;

   // Characters with a meaning of their own
   localparam logic [7:0] CHR_NUL    = 8'h00;
   localparam logic [7:0] CHR_PLUS   = 8'h2B;
   localparam logic [7:0] CHR_MINUS  = 8'h2D;
   localparam logic [7:0] CHR_STAR   = 8'h2A;
   localparam logic [7:0] CHR_SLASH  = 8'h2F;
   localparam logic [7:0] CHR_CARET  = 8'h5E;
   localparam logic [7:0] CHR_LPAREN = 8'h28;
   localparam logic [7:0] CHR_RPAREN = 8'h29;

   // Precedence ranks, offset by one so that unknown operators sit at zero
   localparam logic [2:0] RANK_OTHER = 3'd0;
   localparam logic [2:0] RANK_PAREN = 3'd1;
   localparam logic [2:0] RANK_ADD   = 3'd2;
   localparam logic [2:0] RANK_MUL   = 3'd3;
   localparam logic [2:0] RANK_POW   = 3'd4;

   // One response transaction
   typedef struct packed {
      logic [7:0] out_char;
      logic       has_char;
      logic [1:0] error_code;
      logic       end_of_expression;
      logic       last_of_run;
   } i2p_rsp_type;

   // Letters and digits pass straight through
   function automatic logic i2p_is_alnum(input logic [7:0] c);
      i2p_is_alnum = (c >= 8'h30 && c <= 8'h39) ||
                     (c >= 8'h41 && c <= 8'h5A) ||
                     (c >= 8'h61 && c <= 8'h7A);
   endfunction

   // Operator precedence rank
   function automatic logic [2:0] i2p_rank(input logic [7:0] c);
      logic [2:0] r;
      r = RANK_OTHER;
      unique case (c) inside
         CHR_PLUS, CHR_MINUS: r = RANK_ADD;
         CHR_STAR, CHR_SLASH: r = RANK_MUL;
         CHR_CARET:           r = RANK_POW;
         CHR_LPAREN:          r = RANK_PAREN;
         default:             r = RANK_OTHER;
      endcase
      i2p_rank = r;
   endfunction

endpackage

// ----- hw/rtl/i2p_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module i2p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port (read returns old data on a collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/i2p_ctrl.sv -----
// Sequencer: reads the stack top from RAM, pops, pushes and builds response transactions.
module i2p_ctrl
   import i2p_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_operation,
   input  logic [7:0]                     req_symbol,
   input  logic                           out_free,
   output logic                           out_push,
   output i2p_rsp_type                    out_data,
   output logic                           ram_wr_en,
   output logic [$clog2(STACK_DEPTH)-1:0] ram_wr_addr,
   output logic [7:0]                     ram_wr_data,
   output logic [$clog2(STACK_DEPTH)-1:0] ram_rd_addr,
   input  logic [7:0]                     ram_rd_data
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RUN  = 2'b10
   } i2p_state_type;

   i2p_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          op_ff, op_in;
   logic [7:0]    sym_ff, sym_in;
   logic [7:0]    pend_ff, pend_in;
   logic          pend_vld_ff, pend_vld_in;

   logic          has_top, top_open, not_full, pops_first;
   logic [2:0]    rank_top, rank_sym;
   logic          do_gen, do_fin, do_drain, do_term, do_lit;
   logic          fin_push, fin_pop;
   logic [1:0]    fin_err;
   logic          need_slot, go;
   logic [CW-1:0] rd_ptr;

   // Stack top as read in the previous cycle
   assign has_top  = (count_ff != '0);
   assign top_open = (ram_rd_data == CHR_LPAREN);
   assign not_full = (count_ff < CW'(STACK_DEPTH));
   assign rank_top = i2p_rank(ram_rd_data);
   assign rank_sym = i2p_rank(sym_ff);
   assign pops_first = has_top && !top_open &&
                       ((rank_top > rank_sym) ||
                        ((rank_top == rank_sym) && (sym_ff != CHR_CARET)));

   // Decide this cycle's action from the transaction and the stack top
   always_comb begin
      do_gen   = 1'b0;
      do_fin   = 1'b0;
      do_drain = 1'b0;
      do_term  = 1'b0;
      do_lit   = 1'b0;
      fin_push = 1'b0;
      fin_pop  = 1'b0;
      fin_err  = ERR_NONE;
      if (op_ff == OP_END) begin
         if (has_top) begin
            do_gen = 1'b1;
         end else if (pend_vld_ff) begin
            do_drain = 1'b1;
         end else begin
            do_term = 1'b1;
         end
      end else if (sym_ff == CHR_NUL) begin
         do_fin = 1'b1;
      end else if (i2p_is_alnum(sym_ff)) begin
         do_lit = 1'b1;
      end else if (sym_ff == CHR_LPAREN) begin
         do_fin   = 1'b1;
         fin_push = not_full;
         fin_err  = not_full ? ERR_NONE : ERR_FULL;
      end else if (sym_ff == CHR_RPAREN) begin
         if (has_top && !top_open) begin
            do_gen = 1'b1;
         end else if (has_top) begin
            do_fin  = 1'b1;
            fin_pop = 1'b1;
         end else begin
            do_fin  = 1'b1;
            fin_err = ERR_UNMATCHED;
         end
      end else if (pops_first) begin
         do_gen = 1'b1;
      end else begin
         do_fin   = 1'b1;
         fin_push = not_full;
         fin_err  = not_full ? ERR_NONE : ERR_FULL;
      end
   end

   // A pop only needs the output when it displaces a held character
   assign need_slot = do_gen ? pend_vld_ff : 1'b1;
   assign go        = (state_ff == S_RUN) && (!need_slot || out_free);

   // Next state, stack pointer, held character and response
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      op_in       = op_ff;
      sym_in      = sym_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      out_push    = 1'b0;
      out_data    = '0;
      ram_wr_en   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_operation;
               sym_in      = req_symbol;
               pend_vld_in = 1'b0;
               state_in    = S_RUN;
            end
         end
         S_RUN: begin
            if (go) begin
               if (do_gen) begin
                  // Hold the popped character until we know whether it closes the run
                  out_push          = pend_vld_ff;
                  out_data.out_char = pend_ff;
                  out_data.has_char = 1'b1;
                  pend_in           = ram_rd_data;
                  pend_vld_in       = 1'b1;
                  count_in          = count_ff - CW'(1);
               end else if (do_drain) begin
                  out_push          = 1'b1;
                  out_data.out_char = pend_ff;
                  out_data.has_char = 1'b1;
                  pend_vld_in       = 1'b0;
               end else if (do_term) begin
                  out_push                   = 1'b1;
                  out_data.end_of_expression = 1'b1;
                  out_data.last_of_run       = 1'b1;
                  state_in                   = S_IDLE;
               end else if (do_lit) begin
                  out_push             = 1'b1;
                  out_data.out_char    = sym_ff;
                  out_data.has_char    = 1'b1;
                  out_data.last_of_run = 1'b1;
                  state_in             = S_IDLE;
               end else if (do_fin) begin
                  out_push             = 1'b1;
                  out_data.out_char    = pend_vld_ff ? pend_ff : CHR_NUL;
                  out_data.has_char    = pend_vld_ff;
                  out_data.error_code  = fin_err;
                  out_data.last_of_run = 1'b1;
                  pend_vld_in          = 1'b0;
                  state_in             = S_IDLE;
                  if (fin_push) begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + CW'(1);
                  end else if (fin_pop) begin
                     count_in  = count_ff - CW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Stack RAM addressing: always read the entry below the next pointer.
   // A push only ends a run, and the idle cycle before the next run re-reads
   // the top, so a read never needs data written in the same cycle.
   assign rd_ptr      = count_in - CW'(1);
   assign ram_rd_addr = rd_ptr[AW-1:0];
   assign ram_wr_addr = count_ff[AW-1:0];
   assign ram_wr_data = sym_ff;
   assign req_ready   = (state_ff == S_IDLE);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      sym_ff  <= sym_in;
      pend_ff <= pend_in;
   end

endmodule

// ----- hw/rtl/infix_to_postfix_converter_core.sv -----
// Top level of the shunting-yard infix-to-postfix converter with its response register.
//
// Converts an infix expression, one ASCII character per request transaction, into
// postfix response transactions; an end transaction flushes the operator stack and
// closes with a NUL terminator. The operator stack lives in a RAM with registered
// read and is popped at one entry per cycle unless a stalled response register holds it up.
// A character transaction is accepted, then one step reads the stack top and decides,
// with one more step for every operator it pops; an end transaction pops every stacked
// entry, drains the held character and closes. The single RAM read per cycle sets the
// throughput. Responses wait in an output register, so the block keeps working while
// the consumer stalls until a second response has to be issued. No clearing pass is
// needed after reset; stack RAM data is only used below the stack pointer.
module infix_to_postfix_converter_core
   import i2p_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  logic [7:0] req_symbol,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_has_char,
   output logic [1:0] rsp_error_code,
   output logic       rsp_end_of_expression,
   output logic       rsp_last_of_run
);

   localparam int AW = $clog2(STACK_DEPTH);

   logic          out_free, out_push;
   i2p_rsp_type   out_data;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]    ram_wr_data, ram_rd_data;
   logic          rsp_valid_ff, rsp_valid_in;
   i2p_rsp_type   rsp_data_ff;

   // Operator stack storage
   i2p_ram #(
      .WIDTH (8),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Conversion sequencer
   i2p_ctrl #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_symbol    (req_symbol),
      .out_free      (out_free),
      .out_push      (out_push),
      .out_data      (out_data),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data)
   );

   // Response register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         rsp_data_ff <= out_data;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_out_char          = rsp_data_ff.out_char;
   assign rsp_has_char          = rsp_data_ff.has_char;
   assign rsp_error_code        = rsp_data_ff.error_code;
   assign rsp_end_of_expression = rsp_data_ff.end_of_expression;
   assign rsp_last_of_run       = rsp_data_ff.last_of_run;

endmodule
